// ===== rtl/http_request_tokenizer_unit_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef HTTP_REQUEST_TOKENIZER_UNIT_DEFINES_SVH
`define HTTP_REQUEST_TOKENIZER_UNIT_DEFINES_SVH

// Clocked check, switched off while reset is asserted.
`define HTTOK_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Clocked check that also holds while reset is asserted.
`define HTTOK_ASSERT_RST(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== rtl/httok_pkg.sv =====
package httok_pkg;

  // Result kinds
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_DISCARD = 2'd2;

  // Field codes
  localparam logic [2:0] FLD_METHOD  = 3'd0;
  localparam logic [2:0] FLD_URI     = 3'd1;
  localparam logic [2:0] FLD_VERSION = 3'd2;
  localparam logic [2:0] FLD_HNAME   = 3'd3;
  localparam logic [2:0] FLD_HVALUE  = 3'd4;
  localparam logic [2:0] FLD_BODY    = 3'd5;

  // Characters of interest
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Queue entry: what the front decided about one accepted byte
  typedef struct packed {
    logic       first;      // restart the parse before any feed
    logic       feed_cr;    // a held lone CR is fed first
    logic       feed_main;  // the byte itself (or a line end) is fed
    logic       line_end;   // main feed is a CR LF pair
    logic [7:0] byte_value;
  } tok_entry_t;

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_FF) || (c == CH_VT) || (c == CH_CR);
  endfunction

endpackage

// ===== rtl/httok_if.sv =====
// Byte stream into the tokenizer
interface httok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       first;
  logic       final_req;

  modport source (output valid, output byte_value, output first, output final_req,
                  input ready);
  modport sink   (input valid, input byte_value, input first, input final_req,
                  output ready);
endinterface

// Result stream out of the tokenizer
interface httok_out_if #(
  parameter int unsigned LEN_W = 9,
  parameter int unsigned HDR_W = 5
);
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [2:0]       field;
  logic [7:0]       data_byte;
  logic [LEN_W-1:0] length;
  logic [HDR_W-1:0] header_number;
  logic             overflow;
  logic             done_res;
  logic             run_end;

  modport source (output valid, output kind, output field, output data_byte,
                  output length, output header_number, output overflow,
                  output done_res, output run_end, input ready);
  modport sink   (input valid, input kind, input field, input data_byte,
                  input length, input header_number, input overflow,
                  input done_res, input run_end, output ready);
endinterface

// ===== rtl/httok_front.sv =====
// Front end: accepts bytes, handles the CR lookahead and classifies feeds.
module httok_front
  import httok_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  httok_in_if.sink     req_i,
  input  logic         full_i,
  output logic         push_o,
  output tok_entry_t   entry_o
);

  logic cr_q, cr_d;
  logic held, is_cr, is_lf, accept;

  assign held   = cr_q & ~req_i.first;
  assign is_cr  = (req_i.byte_value == CH_CR);
  assign is_lf  = (req_i.byte_value == CH_LF);
  assign accept = req_i.valid & req_i.ready;

  assign req_i.ready = ~full_i;

  // Work out which feeds this byte causes
  always_comb begin
    entry_o.first      = req_i.first;
    entry_o.byte_value = req_i.byte_value;
    entry_o.feed_cr    = 1'b0;
    entry_o.feed_main  = 1'b0;
    entry_o.line_end   = 1'b0;
    cr_d               = 1'b0;
    if (held) begin
      if (is_lf) begin
        entry_o.feed_main = 1'b1;
        entry_o.line_end  = 1'b1;
      end else begin
        entry_o.feed_cr = 1'b1;
        if (is_cr && !req_i.final_req) begin
          cr_d = 1'b1;
        end else begin
          entry_o.feed_main = 1'b1;
        end
      end
    end else if (is_cr && !req_i.final_req) begin
      cr_d = 1'b1;
    end else begin
      entry_o.feed_main = 1'b1;
    end
  end

  // Only bytes that change something go into the queue
  assign push_o = accept & (entry_o.first | entry_o.feed_cr | entry_o.feed_main);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_q <= 1'b0;
    end else if (accept) begin
      cr_q <= cr_d;
    end
  end

endmodule

// ===== rtl/httok_fifo.sv =====
// Short queue of classified bytes between front and back.
module httok_fifo
  import httok_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  tok_entry_t entry_i,
  output logic       full_o,
  input  logic       pop_i,
  output tok_entry_t entry_o,
  output logic       valid_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tok_entry_t       mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push_ok, pop_ok;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign push_ok = push_i & ~full_o;
  assign pop_ok  = pop_i & valid_o;
  assign entry_o = mem_q[rd_ptr_q];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_ok) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_ok)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push_ok && !pop_ok) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_ok && !push_ok) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/httok_back.sv =====
// Back end: field state machine, one feed a cycle unless a result waits on a full output register, registered result.
module httok_back
  import httok_pkg::*;
#(
  parameter int unsigned MAX_FIELD   = 256,
  parameter int unsigned MAX_HEADERS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tok_entry_t entry_i,
  input  logic       entry_valid_i,
  output logic       pop_o,
  httok_out_if.source res_o
);

  localparam int unsigned LEN_W = $clog2(MAX_FIELD + 1);
  localparam int unsigned HDR_W = $clog2(MAX_HEADERS + 1);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FIELD);
  localparam logic [HDR_W-1:0] MAX_HDR = HDR_W'(MAX_HEADERS);

  // Parse phases
  localparam logic [2:0] PH_METHOD  = 3'd0;
  localparam logic [2:0] PH_URI     = 3'd1;
  localparam logic [2:0] PH_VERSION = 3'd2;
  localparam logic [2:0] PH_HNAME   = 3'd3;
  localparam logic [2:0] PH_HVALUE  = 3'd4;
  localparam logic [2:0] PH_BODY    = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;

  typedef struct packed {
    logic             yield;
    logic [1:0]       kind;
    logic [2:0]       field;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
    logic             done;
    logic [2:0]       ph;
    logic [LEN_W-1:0] pos;
    logic [HDR_W-1:0] hdr;
    logic             ovf;
  } feed_res_t;

  // One feed of a character or a line end into the field state machine
  function automatic feed_res_t feed_step(
    input logic [2:0]       ph,
    input logic [LEN_W-1:0] pos,
    input logic [HDR_W-1:0] hdr,
    input logic             ovf,
    input logic             le,
    input logic [7:0]       c
  );
    feed_res_t        r;
    logic             full, sep, take_data, take_end;
    logic [2:0]       nxt;
    logic [LEN_W-1:0] d_pos;
    full      = (pos >= MAX_LEN);
    sep       = is_sep(c);
    d_pos     = full ? MAX_LEN : pos + 1'b1;
    take_data = 1'b0;
    take_end  = 1'b0;
    nxt       = ph;
    r.yield   = 1'b0;
    r.kind    = KIND_DATA;
    r.field   = ph;
    r.data    = '0;
    r.len     = pos;
    r.done    = 1'b0;
    r.ph      = ph;
    r.pos     = pos;
    r.hdr     = hdr;
    r.ovf     = ovf;
    case (ph)
      PH_METHOD, PH_URI: begin
        if (le || sep) begin
          take_end = 1'b1;
          nxt      = ph + 3'd1;
        end else begin
          take_data = 1'b1;
        end
      end
      PH_VERSION: begin
        if (le) begin
          take_end = 1'b1;
          nxt      = PH_HNAME;
        end else begin
          take_data = 1'b1;
        end
      end
      PH_HNAME: begin
        if (le) begin
          // empty line ends the headers; a partial name is dropped
          r.yield = (pos != '0);
          r.kind  = KIND_DISCARD;
          r.pos   = '0;
          r.ph    = PH_BODY;
        end else if (c == CH_COLON) begin
          if (hdr >= MAX_HDR) r.ovf = 1'b1;
          take_end = 1'b1;
          nxt      = PH_HVALUE;
        end else begin
          take_data = 1'b1;
        end
      end
      PH_HVALUE: begin
        if (le) begin
          take_end = 1'b1;
          nxt      = PH_HNAME;
          r.hdr    = (hdr < MAX_HDR) ? hdr + 1'b1 : hdr;
        end else if (!(pos == '0 && sep)) begin
          take_data = 1'b1;
        end
      end
      PH_BODY: begin
        if (le) begin
          take_end = 1'b1;
          nxt      = PH_DONE;
          r.done   = 1'b1;
        end else begin
          take_data = 1'b1;
        end
      end
      default: ;
    endcase
    if (take_data) begin
      r.yield = 1'b1;
      r.kind  = KIND_DATA;
      r.data  = c;
      r.pos   = d_pos;
      r.len   = d_pos;
      r.ovf   = ovf | full;
    end
    if (take_end) begin
      r.yield = 1'b1;
      r.kind  = KIND_END;
      r.len   = pos;
      r.pos   = '0;
      r.ph    = nxt;
    end
    return r;
  endfunction

  logic [2:0]       ph_q, st_ph;
  logic [LEN_W-1:0] pos_q, st_pos;
  logic [HDR_W-1:0] hdr_q, st_hdr;
  logic             ovf_q, st_ovf;
  logic             step_q;

  logic             use_cr, has_op, has_next, yield_a, out_free, go, run_end;
  logic             cur_le;
  logic [7:0]       cur_c;
  feed_res_t        res_a, res_b;

  logic             out_valid_q;
  logic [1:0]       kind_q;
  logic [2:0]       field_q;
  logic [7:0]       data_q;
  logic [LEN_W-1:0] len_q;
  logic [HDR_W-1:0] hdr_out_q;
  logic             ovf_out_q, done_q, run_end_q;

  // Starting state for this feed, with a request restart applied
  always_comb begin
    if (!step_q && entry_i.first) begin
      st_ph  = PH_METHOD;
      st_pos = '0;
      st_hdr = '0;
      st_ovf = 1'b0;
    end else begin
      st_ph  = ph_q;
      st_pos = pos_q;
      st_hdr = hdr_q;
      st_ovf = ovf_q;
    end
  end

  // Select the feed: a held CR goes before the byte
  assign use_cr   = ~step_q & entry_i.feed_cr;
  assign has_op   = use_cr | entry_i.feed_main;
  assign has_next = use_cr & entry_i.feed_main;
  assign cur_le   = use_cr ? 1'b0 : entry_i.line_end;
  assign cur_c    = use_cr ? CH_CR : entry_i.byte_value;

  assign res_a   = feed_step(st_ph, st_pos, st_hdr, st_ovf, cur_le, cur_c);
  // Lookahead at the second feed decides where run_end falls
  assign res_b   = feed_step(res_a.ph, res_a.pos, res_a.hdr, res_a.ovf,
                             entry_i.line_end, entry_i.byte_value);
  assign run_end = ~has_next | ~res_b.yield;

  assign yield_a  = has_op & res_a.yield;
  assign out_free = ~out_valid_q | res_o.ready;
  assign go       = entry_valid_i & (~yield_a | out_free);
  assign pop_o    = go & ~has_next;

  // Parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_METHOD;
      pos_q  <= '0;
      hdr_q  <= '0;
      ovf_q  <= 1'b0;
      step_q <= 1'b0;
    end else if (go) begin
      step_q <= has_next;
      if (has_op) begin
        ph_q  <= res_a.ph;
        pos_q <= res_a.pos;
        hdr_q <= res_a.hdr;
        ovf_q <= res_a.ovf;
      end else begin
        ph_q  <= st_ph;
        pos_q <= st_pos;
        hdr_q <= st_hdr;
        ovf_q <= st_ovf;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go && yield_a) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && yield_a) begin
      kind_q    <= res_a.kind;
      field_q   <= res_a.field;
      data_q    <= res_a.data;
      len_q     <= res_a.len;
      hdr_out_q <= st_hdr;
      ovf_out_q <= res_a.ovf;
      done_q    <= res_a.done;
      run_end_q <= run_end;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.kind          = kind_q;
  assign res_o.field         = field_q;
  assign res_o.data_byte     = data_q;
  assign res_o.length        = len_q;
  assign res_o.header_number = hdr_out_q;
  assign res_o.overflow      = ovf_out_q;
  assign res_o.done_res      = done_q;
  assign res_o.run_end       = run_end_q;

endmodule

// ===== rtl/http_request_tokenizer_unit.sv =====
// A byte reaches its first result through its queue entry and then the output register.
// Throughput: one byte per cycle while the queue has room; a byte that also releases a
// held lone CR is fed after it, an extra feed absorbed by the 4-entry queue. The parser
// does one feed and the output register one item per cycle unless res_o.ready is low.
// Reset: asynchronous, active low; clears parse state, CR hold, queue and output.
module http_request_tokenizer_unit
  import httok_pkg::*;
#(
  parameter int unsigned MAX_FIELD   = 256,
  parameter int unsigned MAX_HEADERS = 16,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  httok_in_if.sink    req_i,
  httok_out_if.source res_o
);

  tok_entry_t push_entry, head_entry;
  logic       push, full, head_valid, pop;

  httok_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  httok_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (head_entry),
    .valid_o (head_valid)
  );

  httok_back #(
    .MAX_FIELD   (MAX_FIELD),
    .MAX_HEADERS (MAX_HEADERS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (head_entry),
    .entry_valid_i (head_valid),
    .pop_o         (pop),
    .res_o         (res_o)
  );

endmodule

// ===== rtl/httok_chk.sv =====
`include "http_request_tokenizer_unit_defines.svh"

// Port-level checks on the tokenizer results.
module httok_chk
  import httok_pkg::*;
#(
  parameter int unsigned MAX_FIELD   = 256,
  parameter int unsigned MAX_HEADERS = 16,
  parameter int unsigned LEN_W       = 9,
  parameter int unsigned HDR_W       = 5
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             res_valid_i,
  input logic [1:0]       kind_i,
  input logic [2:0]       field_i,
  input logic [7:0]       data_byte_i,
  input logic [LEN_W-1:0] length_i,
  input logic [HDR_W-1:0] header_number_i,
  input logic             done_res_i,
  input logic             run_end_i
);

  `HTTOK_ASSERT(a_done_is_body_end, clk_i, rst_ni,
    res_valid_i && done_res_i |-> kind_i == KIND_END && field_i == FLD_BODY && run_end_i,
    "done item is not the final body field end")

  `HTTOK_ASSERT(a_marker_no_data, clk_i, rst_ni,
    res_valid_i && kind_i != KIND_DATA |-> data_byte_i == 8'd0,
    "marker item carries a data byte")

  `HTTOK_ASSERT(a_counts_bounded, clk_i, rst_ni,
    res_valid_i |-> length_i <= LEN_W'(MAX_FIELD) && header_number_i <= HDR_W'(MAX_HEADERS)
      && (kind_i != KIND_DATA || length_i != '0),
    "length or header count out of range")

  `HTTOK_ASSERT_RST(a_reset_quiet, clk_i,
    !rst_ni |=> !res_valid_i,
    "result valid straight after reset")

endmodule

bind http_request_tokenizer_unit httok_chk #(
  .MAX_FIELD   (MAX_FIELD),
  .MAX_HEADERS (MAX_HEADERS),
  .LEN_W       ($clog2(MAX_FIELD + 1)),
  .HDR_W       ($clog2(MAX_HEADERS + 1))
) u_httok_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_valid_i     (res_o.valid),
  .kind_i          (res_o.kind),
  .field_i         (res_o.field),
  .data_byte_i     (res_o.data_byte),
  .length_i        (res_o.length),
  .header_number_i (res_o.header_number),
  .done_res_i      (res_o.done_res),
  .run_end_i       (res_o.run_end)
);
